// ===== src/nqf_pkg.sv =====
// Shared types, codes and character helpers for the QZQSM sentence framer.
// No dependencies; imported by every module but the port checker.
package nqf_pkg;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_COLLECT,
		PH_CSUM1,
		PH_CSUM2
	} phase_t;

	typedef enum logic [3:0] {
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_P5,
		ST_SAT,
		ST_HEX,
		ST_DONE,
		ST_FAIL
	} stage_t;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [7:0] SAT_LO    = 8'd55;
	localparam logic [7:0] SAT_HI    = 8'd63;
	localparam logic [6:0] HEX_MIN   = 7'd63;
	localparam logic [6:0] HEX_MAX   = 7'd64;
	localparam int         NBYTES    = 32;
	localparam int         BIDX_W    = 5;

	// decoded frame handed from front to back
	typedef struct packed {
		logic [7:0] sat;
		logic       bank;
	} job_t;

	// nibble store write port
	typedef struct packed {
		logic       en;
		logic       bank;
		logic [5:0] idx;
		logic [3:0] data;
	} nib_wr_t;

	// {bad, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
		return r;
	endfunction

	function automatic logic [7:0] prefix_char(input stage_t s);
		logic [7:0] r;
		case (s)
			ST_P0:   r = 8'h51; // Q
			ST_P1:   r = 8'h5A; // Z
			ST_P2:   r = 8'h51; // Q
			ST_P3:   r = 8'h53; // S
			ST_P4:   r = 8'h4D; // M
			ST_P5:   r = 8'h2C; // ,
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== src/nqf_front.sv =====
// Front end: takes characters, tracks checksum and parses the sentence body.
// Writes hex nibbles into the back end's store and pushes a job per good frame.
// Depends on nqf_pkg.
module nqf_front import nqf_pkg::*; #(
	parameter int BUF_SIZE = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       q_full,
	output logic       push,
	output job_t       push_job,
	output nib_wr_t    nib_wr
);

	localparam int CW = $clog2(BUF_SIZE);

	phase_t       phase_q, phase_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [7:0]   xor_q, xor_d;
	logic [3:0]   csh_q, csh_d;
	stage_t       stage_q, stage_d;
	logic [7:0]   sat_q, sat_d;
	logic         seen_q, seen_d;
	logic [6:0]   hcnt_q, hcnt_d;
	logic         ended_q, ended_d;
	logic         wbank_q;

	logic        acc;
	logic [4:0]  hx;
	logic        hbad;
	logic        is_start, is_eol, body_ok;
	logic [11:0] sat_mul;
	logic        frame_ok;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign hx       = hex_decode(in_char);
	assign hbad     = hx[4];
	assign is_start = (in_char == CH_DOLLAR);
	assign is_eol   = (in_char == CH_CR) || (in_char == CH_LF);
	assign body_ok  = (cnt_q < CW'(BUF_SIZE - 1));
	assign sat_mul  = {1'b0, sat_q, 3'b000} + {3'b000, sat_q, 1'b0}
		+ {8'h00, 4'(in_char - CH_ZERO)};

	assign frame_ok = (phase_q == PH_CSUM2) && !hbad && ({csh_q, hx[3:0]} == xor_q)
		&& (stage_q == ST_HEX || stage_q == ST_DONE)
		&& (hcnt_q == HEX_MIN || hcnt_q == HEX_MAX);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			if (is_start) begin
				phase_d = PH_COLLECT;
			end else begin
				case (phase_q)
					PH_COLLECT: begin
						if (in_char == CH_STAR) phase_d = PH_CSUM1;
						else if (is_eol) phase_d = PH_WAIT;
					end
					PH_CSUM1: phase_d = hbad ? PH_WAIT : PH_CSUM2;
					PH_CSUM2: phase_d = PH_WAIT;
					default:  phase_d = PH_WAIT;
				endcase
			end
		end
	end

	// datapath and parser
	always_comb begin
		cnt_d   = cnt_q;
		xor_d   = xor_q;
		csh_d   = csh_q;
		stage_d = stage_q;
		sat_d   = sat_q;
		seen_d  = seen_q;
		hcnt_d  = hcnt_q;
		ended_d = ended_q;
		nib_wr  = '{en: 1'b0, bank: wbank_q, idx: hcnt_q[5:0], data: hx[3:0]};
		push    = 1'b0;
		push_job.bank = wbank_q;
		push_job.sat  = (sat_q >= SAT_LO && sat_q <= SAT_HI) ? (sat_q | 8'h80) : sat_q;
		if (acc) begin
			if (is_start) begin
				cnt_d   = '0;
				xor_d   = '0;
				stage_d = ST_P0;
				sat_d   = '0;
				seen_d  = 1'b0;
				hcnt_d  = '0;
				ended_d = 1'b0;
			end else begin
				case (phase_q)
					PH_COLLECT: begin
						if (in_char == CH_STAR) begin
						end else if (is_eol) begin
							cnt_d = '0;
							xor_d = '0;
							csh_d = '0;
						end else if (body_ok) begin
							xor_d = xor_q ^ in_char;
							cnt_d = cnt_q + 1'b1;
							if (!ended_q) begin
								if (in_char == CH_NUL) begin
									ended_d = 1'b1;
									if (stage_q == ST_HEX) stage_d = ST_DONE;
									else if (stage_q != ST_DONE) stage_d = ST_FAIL;
								end else if (stage_q inside {[ST_P0:ST_P5]}) begin
									if (in_char == prefix_char(stage_q))
										stage_d = stage_t'(stage_q + 4'd1);
									else
										stage_d = ST_FAIL;
								end else if (stage_q == ST_SAT) begin
									if (in_char >= CH_ZERO && in_char <= CH_NINE) begin
										seen_d = 1'b1;
										if (sat_mul > 12'd255) stage_d = ST_FAIL;
										else sat_d = sat_mul[7:0];
									end else if (in_char == CH_COMMA && seen_q) begin
										stage_d = ST_HEX;
									end else begin
										stage_d = ST_FAIL;
									end
								end else if (stage_q == ST_HEX) begin
									if (hbad) begin
										stage_d = ST_DONE;
									end else if (hcnt_q >= HEX_MAX) begin
										stage_d = ST_FAIL;
									end else begin
										nib_wr.en = 1'b1;
										hcnt_d    = hcnt_q + 1'b1;
									end
								end
							end
						end
					end
					PH_CSUM1: begin
						if (hbad) begin
							cnt_d = '0;
							xor_d = '0;
							csh_d = '0;
						end else begin
							csh_d = hx[3:0];
						end
					end
					PH_CSUM2: begin
						if (hbad) begin
							cnt_d = '0;
							xor_d = '0;
							csh_d = '0;
						end
						push = frame_ok;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			cnt_q   <= '0;
			xor_q   <= '0;
			csh_q   <= '0;
			stage_q <= ST_P0;
			sat_q   <= '0;
			seen_q  <= 1'b0;
			hcnt_q  <= '0;
			ended_q <= 1'b0;
			wbank_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			xor_q   <= xor_d;
			csh_q   <= csh_d;
			stage_q <= stage_d;
			sat_q   <= sat_d;
			seen_q  <= seen_d;
			hcnt_q  <= hcnt_d;
			ended_q <= ended_d;
			if (push) wbank_q <= !wbank_q;
		end
	end

endmodule

// ===== src/nqf_queue.sv =====
// Two-entry job queue between front and back ends.
// Depends on nqf_pkg.
module nqf_queue import nqf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== src/nqf_back.sv =====
// Back end (needs nqf_pkg): double-banked nibble store, 32-byte payload
// emitter, one byte per cycle unless stalled, behind an output register.
module nqf_back import nqf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  nib_wr_t     nib_wr,
	input  logic        job_valid,
	input  job_t        job,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [BIDX_W-1:0] out_index,
	output logic [7:0]  out_sat,
	output logic        out_last
);

	localparam logic [BIDX_W-1:0] LAST_IDX = BIDX_W'(NBYTES - 1);

	logic [3:0] mem_hi [64];
	logic [3:0] mem_lo [64];

	logic [BIDX_W-1:0] idx_q;
	logic              valid_s1;
	logic [BIDX_W-1:0] idx_s1;
	logic [7:0]        sat_s1;
	logic [3:0]        hi_s1, lo_s1;
	logic              adv_s1, issue;

	assign adv_s1 = valid_s1 && (!out_valid || out_ready);
	assign issue  = job_valid && (!valid_s1 || adv_s1);
	assign pop    = issue && (idx_q == LAST_IDX);

	always_ff @(posedge clk) begin
		if (nib_wr.en && !nib_wr.idx[0]) mem_hi[{nib_wr.bank, nib_wr.idx[5:1]}] <= nib_wr.data;
		if (nib_wr.en && nib_wr.idx[0])  mem_lo[{nib_wr.bank, nib_wr.idx[5:1]}] <= nib_wr.data;
		if (issue) begin
			hi_s1  <= mem_hi[{job.bank, idx_q}];
			lo_s1  <= mem_lo[{job.bank, idx_q}];
			idx_s1 <= idx_q;
			sat_s1 <= job.sat;
		end
		if (adv_s1) begin
			out_byte  <= {hi_s1, (idx_s1 == LAST_IDX) ? 4'h0 : lo_s1};
			out_index <= idx_s1;
			out_sat   <= sat_s1;
			out_last  <= (idx_s1 == LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (issue) idx_q <= idx_q + 1'b1;
			if (issue) valid_s1 <= 1'b1;
			else if (adv_s1) valid_s1 <= 1'b0;
			if (adv_s1) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule

// ===== src/nmea_qzss_message_framer.sv =====
// Top level of the QZQSM sentence framer: front parser, job queue, payload emitter.
// Depends on nqf_pkg, nqf_front, nqf_queue, nqf_back.
//
// One character is taken per clock while the job queue is not full. A sentence
// that passes its checksum and reads as QZQSM,<sat>,<63 or 64 hex digits> yields
// 32 payload items, one per clock while m_axis_tready is high. The nibble store
// has two banks, so one frame can be emitted while the next is parsed; input is
// held off (s_axis_tready low) only while two decoded frames are still waiting
// to be read out of the store.
module nmea_qzss_message_framer import nqf_pkg::*; #(
	parameter int BUF_SIZE = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] payload_byte, [12:8] byte_index,
	                                   // [20:13] sat_id, [23:21] zero
	output logic        m_axis_tlast   // last_byte
);

	logic    q_full, q_empty, push, pop;
	job_t    push_job, head;
	nib_wr_t nib_wr;
	logic [7:0]        out_byte, out_sat;
	logic [BIDX_W-1:0] out_index;

	nqf_front #(.BUF_SIZE(BUF_SIZE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job),
		.nib_wr   (nib_wr)
	);

	nqf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	nqf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nib_wr    (nib_wr),
		.job_valid (!q_empty),
		.job       (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (out_byte),
		.out_index (out_index),
		.out_sat   (out_sat),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, out_sat, out_index, out_byte};

endmodule

// ===== src/nqf_checker.sv =====
// Port-level checks for the QZQSM sentence framer, bound to the top level.
// Depends only on the top level's ports.
module nqf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[12:8] == 5'd31)))
		else $error("tlast does not match byte index");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == 4'h0)
		else $error("final byte low nibble not zero");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[20:13] < 8'd55 || m_axis_tdata[20:13] > 8'd63))
		else $error("satellite number not remapped");

endmodule

bind nmea_qzss_message_framer nqf_checker u_nqf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== tb/nmea_qzss_message_framer_tb.sv =====
// Testbench for nmea_qzss_message_framer: drives NMEA sentences one character per item
// and checks every payload item against generated digits or an in-bench sentence decoder.
// Depends on nqf_pkg and the framer RTL only.
module nmea_qzss_message_framer_tb;
	import nqf_pkg::*;

	localparam int BUF_SIZE    = 128;
	localparam int HOLD_CYCLES = 2500;
	localparam int CYCLE_LIMIT = 4000000;

	localparam logic [47:0] QZ_TAG = "QZQSM,";
	localparam logic [63:0] BAD_CS = "Gg:/@_Z.";

	typedef enum int {
		S_NOISE,
		S_GOOD,
		S_LEADZ,
		S_TRAIL,
		S_LONG,
		S_NULEND,
		S_RESTART,
		S_NULEARLY,
		S_BADPFX,
		S_SATCHAR,
		S_NODIG,
		S_SHORT,
		S_BADCS1,
		S_BADCS2,
		S_CSBAD,
		S_CR,
		S_LF
	} sent_kind_t;

	typedef enum int {
		W_MODEL,
		W_NONE,
		W_FRAME
	} want_t;

	typedef struct packed {
		sent_kind_t kind;
		int         sat;
		int         nhex;
		int         cmode; // 0 upper, 1 lower, 2 mixed
		want_t      want;
		int         tsat;
	} row_t;

	typedef struct packed {
		logic [7:0] pbyte;
		logic [4:0] idx;
		logic [7:0] sid;
		logic       tail;
	} pay_item_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00; // [7:0] in_char
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;          // [7:0] payload_byte, [12:8] byte_index, [20:13] sat_id
	logic        m_axis_tlast;

	// decoder state
	phase_t     sent_phase = PH_WAIT;
	int         body_len   = 0;
	logic [7:0] body_xor   = 8'h00;
	logic [3:0] cs_high    = 4'h0;
	stage_t     text_stage = ST_P0;
	logic [7:0] sat_acc    = 8'h00;
	bit         sat_digit  = 1'b0;
	int         hex_cnt    = 0;
	bit         text_done  = 1'b0;
	logic [3:0] nib_mem [64] = '{default: 4'h0};

	pay_item_t  frame_q [$];
	pay_item_t  frame_head;
	logic [7:0] line_q [$];
	logic [3:0] gen_nibs [64] = '{default: 4'h0};
	int         cs_pos;

	int  err_cnt    = 0;
	int  chars_sent = 0;
	int  frames_due = 0;
	int  cycle_cnt  = 0;
	int  rx_wait    = 0;
	bit  quiet      = 1'b0;
	bit  hold_on    = 1'b0;
	bit  press_go   = 1'b0;

	row_t plan [26] = '{
		'{S_NOISE,     0,  8, 0, W_NONE,  0},
		'{S_GOOD,      0, 63, 0, W_FRAME, 0},
		'{S_GOOD,    255, 64, 1, W_FRAME, 255},
		'{S_GOOD,     55, 63, 2, W_FRAME, 183},
		'{S_GOOD,     63, 64, 0, W_FRAME, 191},
		'{S_GOOD,     54, 63, 1, W_FRAME, 54},
		'{S_GOOD,     64, 64, 2, W_FRAME, 64},
		'{S_GOOD,    100, 62, 0, W_NONE,  0},
		'{S_GOOD,    100, 65, 0, W_NONE,  0},
		'{S_GOOD,    256, 63, 0, W_NONE,  0},
		'{S_LEADZ,     7, 63, 2, W_MODEL, 0},
		'{S_TRAIL,   128, 63, 1, W_MODEL, 0},
		'{S_LONG,    200, 64, 2, W_MODEL, 0},
		'{S_NULEND,    9, 63, 0, W_MODEL, 0},
		'{S_NULEARLY,  5, 63, 0, W_NONE,  0},
		'{S_BADPFX,    5, 63, 0, W_NONE,  0},
		'{S_SATCHAR,   5, 63, 0, W_NONE,  0},
		'{S_NODIG,     5, 63, 0, W_NONE,  0},
		'{S_SHORT,    12,  0, 0, W_NONE,  0},
		'{S_BADCS1,    5, 63, 0, W_NONE,  0},
		'{S_BADCS2,    5, 63, 1, W_NONE,  0},
		'{S_CSBAD,     5, 63, 0, W_NONE,  0},
		'{S_RESTART,  60, 64, 2, W_MODEL, 0},
		'{S_CR,        5, 63, 0, W_NONE,  0},
		'{S_LF,        5, 63, 0, W_NONE,  0},
		'{S_GOOD,    199, 64, 2, W_MODEL, 0}
	};

	nmea_qzss_message_framer #(
		.BUF_SIZE(BUF_SIZE)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic int nib_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit low);
		if (n < 10) return 8'(CH_ZERO + n);
		return 8'((low ? "a" : "A") + n - 10);
	endfunction

	function automatic bit pick_low(input int cmode);
		return cmode == 1 || (cmode == 2 && $urandom_range(0, 1) == 1);
	endfunction

	function automatic logic [7:0] filler();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_DOLLAR || c == CH_STAR || c == CH_CR || c == CH_LF);
		return c;
	endfunction

	task automatic push_frame(input logic [3:0] nibs [64], input logic [7:0] sid);
		pay_item_t it;
		for (int k = 0; k < NBYTES; k++) begin
			it.pbyte = {nibs[2 * k], (k < NBYTES - 1) ? nibs[2 * k + 1] : 4'h0};
			it.idx   = 5'(k);
			it.sid   = sid;
			it.tail  = (k == NBYTES - 1);
			frame_q.push_back(it);
		end
	endtask

	task automatic drop_sentence();
		sent_phase = PH_WAIT;
		body_len   = 0;
		body_xor   = 8'h00;
		cs_high    = 4'h0;
	endtask

	task automatic parse_text_char(input logic [7:0] c);
		int d;
		int v;
		if (text_done) return;
		if (c == CH_NUL) begin
			text_done = 1'b1;
			if (text_stage == ST_HEX) text_stage = ST_DONE;
			else if (text_stage != ST_DONE) text_stage = ST_FAIL;
			return;
		end
		if (text_stage < ST_SAT) begin
			if (c == QZ_TAG[47 - 8 * int'(text_stage) -: 8]) text_stage = stage_t'(text_stage + 1);
			else text_stage = ST_FAIL;
		end else if (text_stage == ST_SAT) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				v = int'(sat_acc) * 10 + int'(c - CH_ZERO);
				sat_digit = 1'b1;
				if (v > 255) text_stage = ST_FAIL;
				else sat_acc = v[7:0];
			end else if (c == CH_COMMA && sat_digit) begin
				text_stage = ST_HEX;
			end else begin
				text_stage = ST_FAIL;
			end
		end else if (text_stage == ST_HEX) begin
			d = nib_of(c);
			if (d < 0) begin
				text_stage = ST_DONE;
			end else if (hex_cnt >= 64) begin
				text_stage = ST_FAIL;
			end else begin
				nib_mem[hex_cnt] = d[3:0];
				hex_cnt++;
			end
		end
	endtask

	// advance the sentence decoder by one accepted character
	task automatic decode_char(input logic [7:0] c, input bit keep);
		int d;
		logic [7:0] sid;
		if (c == CH_DOLLAR) begin
			body_len   = 0;
			body_xor   = 8'h00;
			sent_phase = PH_COLLECT;
			text_stage = ST_P0;
			sat_acc    = 8'h00;
			sat_digit  = 1'b0;
			hex_cnt    = 0;
			text_done  = 1'b0;
			return;
		end
		case (sent_phase)
			PH_COLLECT: begin
				if (c == CH_STAR) begin
					sent_phase = PH_CSUM1;
				end else if (c == CH_CR || c == CH_LF) begin
					drop_sentence();
				end else if (body_len < BUF_SIZE - 1) begin
					body_xor ^= c;
					body_len++;
					parse_text_char(c);
				end
			end
			PH_CSUM1: begin
				d = nib_of(c);
				if (d < 0) begin
					drop_sentence();
				end else begin
					cs_high    = d[3:0];
					sent_phase = PH_CSUM2;
				end
			end
			PH_CSUM2: begin
				d = nib_of(c);
				if (d < 0) begin
					drop_sentence();
				end else begin
					sent_phase = PH_WAIT;
					if ({cs_high, d[3:0]} == body_xor
							&& (text_stage == ST_HEX || text_stage == ST_DONE)
							&& (hex_cnt == 63 || hex_cnt == 64)) begin
						sid = sat_acc;
						if (sid >= SAT_LO && sid <= SAT_HI) sid = sid + 8'd128;
						frames_due++;
						if (keep) push_frame(nib_mem, sid);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic make_line(input row_t r);
		logic [7:0] body [$];
		string      st;
		logic [7:0] sum;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [3:0] nb;
		int         p;
		int         n;
		line_q.delete();
		if (r.kind == S_NOISE) begin
			line_q.push_back(8'h00);
			line_q.push_back(8'hFF);
			for (int i = 0; i < r.nhex; i++) line_q.push_back(8'($urandom_range(0, 255)));
			cs_pos = -1;
			return;
		end
		for (int i = 0; i < 6; i++)
			body.push_back((r.kind == S_BADPFX && i == 4) ? 8'h4E : QZ_TAG[47 - 8 * i -: 8]);
		if (r.kind == S_NULEARLY) body.push_back(CH_NUL);
		case (r.kind)
			S_NODIG: st = "";
			S_LEADZ: st = $sformatf("00%0d", r.sat);
			default: st = $sformatf("%0d", r.sat);
		endcase
		if (r.kind == S_SATCHAR) st = {st, "x"};
		for (int i = 0; i < st.len(); i++) body.push_back(st[i]);
		if (r.kind != S_SHORT) begin
			body.push_back(CH_COMMA);
			for (int i = 0; i < r.nhex; i++) begin
				nb = 4'($urandom_range(0, 15));
				gen_nibs[i % 64] = nb;
				body.push_back(hex_char(nb, pick_low(r.cmode)));
			end
		end
		case (r.kind)
			S_TRAIL: begin
				body.push_back(CH_COMMA);
				n = $urandom_range(1, 10);
				repeat (n) body.push_back(filler());
			end
			S_LONG: begin
				body.push_back(CH_COMMA);
				n = BUF_SIZE - 1 + $urandom_range(1, 20);
				while (body.size() < n) body.push_back(filler());
			end
			S_NULEND: begin
				body.push_back(CH_NUL);
				n = $urandom_range(1, 6);
				repeat (n) body.push_back(hex_char(4'($urandom_range(0, 15)), pick_low(2)));
				n = $urandom_range(0, 4);
				repeat (n) body.push_back(filler());
			end
			default: ;
		endcase
		sum = 8'h00;
		for (int i = 0; i < body.size() && i < BUF_SIZE - 1; i++) sum ^= body[i];
		if (r.kind == S_CSBAD) sum ^= 8'(1 << $urandom_range(0, 7));
		hi = hex_char(sum[7:4], pick_low(r.cmode));
		lo = hex_char(sum[3:0], pick_low(r.cmode));
		if (r.kind == S_BADCS1) hi = BAD_CS[8 * $urandom_range(0, 7) +: 8];
		if (r.kind == S_BADCS2) lo = BAD_CS[8 * $urandom_range(0, 7) +: 8];
		if (r.kind == S_RESTART) begin
			line_q.push_back(CH_DOLLAR);
			n = $urandom_range(1, 20);
			repeat (n) line_q.push_back(filler());
		end
		line_q.push_back(CH_DOLLAR);
		p = (r.kind == S_CR || r.kind == S_LF) ? $urandom_range(0, body.size() - 1) : -1;
		foreach (body[i]) begin
			if (i == p) line_q.push_back(r.kind == S_CR ? CH_CR : CH_LF);
			line_q.push_back(body[i]);
		end
		line_q.push_back(CH_STAR);
		line_q.push_back(hi);
		line_q.push_back(lo);
		cs_pos = line_q.size() - 1;
		line_q.push_back(CH_CR);
		line_q.push_back(CH_LF);
	endtask

	task automatic send_char(input logic [7:0] c, input bit keep);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		do @(posedge clk); while (!s_axis_tready);
		chars_sent++;
		decode_char(c, keep);
	endtask

	task automatic send_line(input row_t r);
		make_line(r);
		foreach (line_q[i]) begin
			send_char(line_q[i], r.want == W_MODEL);
			if (i == cs_pos && r.want == W_FRAME) push_frame(gen_nibs, r.tsat[7:0]);
		end
	endtask

	function automatic row_t random_row(input bit force_good);
		row_t r;
		int   pick;
		r.sat   = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 63) : $urandom_range(0, 255);
		if (!force_good && $urandom_range(0, 29) == 0) r.sat = $urandom_range(256, 999);
		r.nhex  = $urandom_range(63, 64);
		r.cmode = $urandom_range(0, 2);
		r.want  = W_MODEL;
		r.tsat  = 0;
		pick    = force_good ? 0 : $urandom_range(0, 99);
		if (pick < 50) r.kind = S_GOOD;
		else if (pick < 58) r.kind = S_TRAIL;
		else if (pick < 63) r.kind = S_LONG;
		else if (pick < 68) r.kind = S_NULEND;
		else if (pick < 72) r.kind = S_LEADZ;
		else if (pick < 76) r.kind = S_RESTART;
		else if (pick < 80) begin
			r.kind = S_NOISE;
			r.nhex = $urandom_range(1, 12);
		end else if (pick < 84) begin
			r.kind = S_GOOD;
			r.nhex = (pick < 82) ? 62 : 65;
		end else begin
			r.kind = sent_kind_t'($urandom_range(S_NULEARLY, S_LF));
		end
		return r;
	endfunction

	// receiver pacing
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) rx_wait = draw_gap();
		else if (rx_wait > 0) rx_wait = rx_wait - 1;
		m_axis_tready <= (rx_wait == 0) && !hold_on;
	end

	// long receiver stall so the frame buffer fills and input backs up
	initial begin
		wait (press_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (frame_q.size() == 0) begin
				$error("unexpected payload item: tdata %06h tlast %0b", m_axis_tdata, m_axis_tlast);
				err_cnt++;
			end else begin
				frame_head = frame_q.pop_front();
				if (m_axis_tdata[7:0] !== frame_head.pbyte) begin
					$error("payload_byte: expected %02h, got %02h",
						frame_head.pbyte, m_axis_tdata[7:0]);
					err_cnt++;
				end
				if (m_axis_tdata[12:8] !== frame_head.idx) begin
					$error("byte_index: expected %0d, got %0d",
						frame_head.idx, m_axis_tdata[12:8]);
					err_cnt++;
				end
				if (m_axis_tdata[20:13] !== frame_head.sid) begin
					$error("sat_id: expected %0d, got %0d",
						frame_head.sid, m_axis_tdata[20:13]);
					err_cnt++;
				end
				if (m_axis_tlast !== frame_head.tail) begin
					$error("last_byte: expected %0b, got %0b", frame_head.tail, m_axis_tlast);
					err_cnt++;
				end
				if (m_axis_tdata[23:21] !== 3'b000) begin
					$error("pad: expected 0, got %0h", m_axis_tdata[23:21]);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int n;
		int base_chars;
		int base_frames;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			quiet <= ($urandom_range(0, 3) == 0);
			send_line(plan[i]);
		end
		base_chars  = chars_sent;
		base_frames = frames_due;
		press_go    = 1'b1;
		n           = 0;
		// first few sentences are well formed so they pile up behind the stall
		while (n < 4 || chars_sent < base_chars + 130 || frames_due < base_frames + 8) begin
			quiet <= ($urandom_range(0, 3) == 0);
			send_line(random_row(n < 4));
			n++;
		end
		s_axis_tvalid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (err_cnt == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
